>>> hw/rtl/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants for the toroidal life automaton: opcodes,
// register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lat_pkg;

  localparam int CFG_W     = 7;  // size register width
  localparam int COORD_W   = 6;  // row / column field width
  localparam int CFG_IDX_W = 2;  // register index width
  localparam int CNT_W     = 4;  // neighbour count, 0..8

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  // B3/S23
  localparam logic [CNT_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_GEN   = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_MODIFY,
    ST_G_UP,
    ST_G_MID,
    ST_G_DN,
    ST_G_CAP,
    ST_G_WRITE,
    ST_C_READ,
    ST_C_WRITE
  } state_t;

  typedef enum logic [1:0] {
    RD_ITEM,
    RD_UP,
    RD_MID,
    RD_DN
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_MODIFY,
    WR_COPY
  } wr_sel_t;

  typedef struct packed {
    logic    item_load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cell_we;
    wr_sel_t wr_sel;
    logic    next_we;
    logic    next_rd_en;
    logic    row_clr;
    logic    row_inc;
    logic    cap_up;
    logic    cap_mid;
    logic    cap_dn;
    logic    res_load;
    logic    res_cell;
  } lat_cmd_t;

  typedef struct packed {
    opcode_t item_op;
    logic    item_oor;
    logic    row_last;
    logic    clear_last;
  } lat_status_t;

endpackage

>>> hw/rtl/lat_ram.sv
// ----------------------------------------------------------------------------
// lat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lat_rule.sv
// ----------------------------------------------------------------------------
// lat_rule
// One board row of B3/S23 update lanes with column wraparound at the
// configured width. Lanes beyond the width keep their old value.
// ----------------------------------------------------------------------------
module lat_rule import lat_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0]               up_row,
  input  logic [MAX_WIDTH-1:0]               mid_row,
  input  logic [MAX_WIDTH-1:0]               dn_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
  output logic [MAX_WIDTH-1:0]               new_row
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CA = $clog2(MAX_WIDTH);

  logic [WW-1:0] last_col;
  logic [CA-1:0] last_idx;

  assign last_col = width - WW'(1);
  assign last_idx = CA'(last_col);

  for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
    logic             is_last;
    logic             in_use;
    logic             u_l, u_r, m_l, m_r, d_l, d_r;
    logic [CNT_W-1:0] cnt;
    logic             rule;

    assign is_last = (last_col == WW'(c));
    assign in_use  = (WW'(c) < width);

    if (c == 0) begin : g_left_wrap
      assign u_l = up_row[last_idx];
      assign m_l = mid_row[last_idx];
      assign d_l = dn_row[last_idx];
    end else begin : g_left
      assign u_l = up_row[c-1];
      assign m_l = mid_row[c-1];
      assign d_l = dn_row[c-1];
    end

    if (c == MAX_WIDTH - 1) begin : g_right_wrap
      assign u_r = up_row[0];
      assign m_r = mid_row[0];
      assign d_r = dn_row[0];
    end else begin : g_right
      assign u_r = is_last ? up_row[0]  : up_row[c+1];
      assign m_r = is_last ? mid_row[0] : mid_row[c+1];
      assign d_r = is_last ? dn_row[0]  : dn_row[c+1];
    end

    assign cnt = CNT_W'(u_l) + CNT_W'(up_row[c]) + CNT_W'(u_r)
               + CNT_W'(m_l) + CNT_W'(m_r)
               + CNT_W'(d_l) + CNT_W'(dn_row[c]) + CNT_W'(d_r);

    assign rule = mid_row[c] ? ((cnt == SURVIVE_MIN) || (cnt == BIRTH_COUNT))
                             : (cnt == BIRTH_COUNT);

    assign new_row[c] = in_use ? rule : mid_row[c];
  end

endmodule

>>> hw/rtl/lat_ctrl.sv
// ----------------------------------------------------------------------------
// lat_ctrl
// Sequencer: reset clearing sweep, item dispatch, cell read-modify-write,
// generation row walk and copy-back.
// ----------------------------------------------------------------------------
module lat_ctrl import lat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  lat_status_t status,
  output lat_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:     if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (status.item_oor) begin
          state_next = ST_IDLE;
        end else begin
          case (status.item_op)
            OP_WRITE: state_next = ST_MODIFY;
            OP_READ:  state_next = ST_READ;
            OP_GEN:   state_next = ST_G_UP;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:     state_next = ST_IDLE;
      ST_MODIFY:   state_next = ST_IDLE;
      ST_G_UP:     state_next = ST_G_MID;
      ST_G_MID:    state_next = ST_G_DN;
      ST_G_DN:     state_next = ST_G_CAP;
      ST_G_CAP:    state_next = ST_G_WRITE;
      ST_G_WRITE:  state_next = status.row_last ? ST_C_READ : ST_G_UP;
      ST_C_READ:   state_next = ST_C_WRITE;
      ST_C_WRITE:  state_next = status.row_last ? ST_IDLE : ST_C_READ;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.cell_we = 1'b1;
        cmd.wr_sel  = WR_CLEAR;
        cmd.row_inc = ~status.clear_last;
      end
      ST_IDLE: begin
        cmd.item_load = start;
      end
      ST_DISPATCH: begin
        if (status.item_oor) begin
          cmd.res_load = 1'b1;
        end else begin
          case (status.item_op)
            OP_WRITE, OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ITEM;
            end
            OP_GEN:  cmd.row_clr  = 1'b1;
            default: cmd.res_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_cell = 1'b1;
      end
      ST_MODIFY: begin
        cmd.cell_we  = 1'b1;
        cmd.wr_sel   = WR_MODIFY;
        cmd.res_load = 1'b1;
      end
      ST_G_UP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_UP;
      end
      ST_G_MID: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_MID;
        cmd.cap_up = 1'b1;
      end
      ST_G_DN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_DN;
        cmd.cap_mid = 1'b1;
      end
      ST_G_CAP: begin
        cmd.cap_dn = 1'b1;
      end
      ST_G_WRITE: begin
        cmd.next_we = 1'b1;
        cmd.row_clr = status.row_last;
        cmd.row_inc = ~status.row_last;
      end
      ST_C_READ: begin
        cmd.next_rd_en = 1'b1;
      end
      ST_C_WRITE: begin
        cmd.cell_we  = 1'b1;
        cmd.wr_sel   = WR_COPY;
        cmd.res_load = status.row_last;
        cmd.row_inc  = ~status.row_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/lat_datapath.sv
// ----------------------------------------------------------------------------
// lat_datapath
// Size registers, item registers, the two row-wide board memories, the
// three-row window and the result registers.
// ----------------------------------------------------------------------------
module lat_datapath import lat_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lat_cmd_t             cmd,
  output lat_status_t          status,
  input  logic [1:0]           opcode,
  input  logic [COORD_W-1:0]   row,
  input  logic [COORD_W-1:0]   col,
  input  logic                 cell_in,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic                 cell_value,
  output logic                 out_of_range
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CA = $clog2(MAX_WIDTH);
  localparam int RA = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0]   board_width, board_height;
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;

  opcode_t            item_op;
  logic [COORD_W-1:0] item_row, item_col;
  logic               item_cell;

  logic [RA-1:0]      gen_row;
  logic [HW-1:0]      row_ext, up_ext, dn_ext;
  logic [RA-1:0]      rd_addr, cell_waddr;
  logic [CA-1:0]      col_idx;

  logic [MAX_WIDTH-1:0] cell_rdata, cell_wdata, next_rdata, new_row;
  logic [MAX_WIDTH-1:0] up_row, mid_row, dn_row, mod_row;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= SIZE_RESET;
      board_height <= SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOARD_WIDTH:  board_width  <= cfg_data;
        CFG_BOARD_HEIGHT: board_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, anything above the maximum as the maximum
  always_comb begin
    if (board_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(board_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(board_width);
    end
    if (board_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(board_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(board_height);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op   <= opcode_t'(opcode);
      item_row  <= row;
      item_col  <= col;
      item_cell <= cell_in;
    end
  end

  // row walk counter
  always_ff @(posedge clk) begin
    if (rst || cmd.row_clr) begin
      gen_row <= '0;
    end else if (cmd.row_inc) begin
      gen_row <= gen_row + RA'(1);
    end
  end

  assign row_ext = HW'(gen_row);
  assign up_ext  = (gen_row == '0) ? (h_eff - HW'(1)) : (row_ext - HW'(1));
  assign dn_ext  = ((row_ext + HW'(1)) >= h_eff) ? '0 : (row_ext + HW'(1));

  assign status.item_op    = item_op;
  assign status.item_oor   = ((item_op == OP_WRITE) || (item_op == OP_READ)) &&
                             ((32'(item_row) >= 32'(h_eff)) ||
                              (32'(item_col) >= 32'(w_eff)));
  assign status.row_last   = (row_ext == (h_eff - HW'(1)));
  assign status.clear_last = (gen_row == RA'(MAX_HEIGHT - 1));

  assign col_idx = CA'(item_col);

  always_comb begin
    case (cmd.rd_sel)
      RD_ITEM: rd_addr = RA'(item_row);
      RD_UP:   rd_addr = RA'(up_ext);
      RD_MID:  rd_addr = gen_row;
      RD_DN:   rd_addr = RA'(dn_ext);
      default: rd_addr = gen_row;
    endcase
  end

  always_comb begin
    mod_row          = cell_rdata;
    mod_row[col_idx] = item_cell;
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_CLEAR: begin
        cell_waddr = gen_row;
        cell_wdata = '0;
      end
      WR_MODIFY: begin
        cell_waddr = RA'(item_row);
        cell_wdata = mod_row;
      end
      WR_COPY: begin
        cell_waddr = gen_row;
        cell_wdata = next_rdata;
      end
      default: begin
        cell_waddr = gen_row;
        cell_wdata = next_rdata;
      end
    endcase
  end

  lat_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cmd.cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(cell_rdata)
  );

  lat_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_next_ram (
    .clk  (clk),
    .we   (cmd.next_we),
    .waddr(gen_row),
    .wdata(new_row),
    .re   (cmd.next_rd_en),
    .raddr(gen_row),
    .rdata(next_rdata)
  );

  // three-row window
  always_ff @(posedge clk) begin
    if (cmd.cap_up) begin
      up_row <= cell_rdata;
    end
    if (cmd.cap_mid) begin
      mid_row <= cell_rdata;
    end
    if (cmd.cap_dn) begin
      dn_row <= cell_rdata;
    end
  end

  lat_rule #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_rule (
    .up_row (up_row),
    .mid_row(mid_row),
    .dn_row (dn_row),
    .width  (w_eff),
    .new_row(new_row)
  );

  // result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      cell_value   <= cmd.res_cell ? cell_rdata[col_idx] : 1'b0;
      out_of_range <= status.item_oor;
    end
  end

endmodule

>>> hw/rtl/life_automaton_torus.sv
// ----------------------------------------------------------------------------
// life_automaton_torus
// B3/S23 cellular automaton on a wrapped one-bit board with cell write,
// cell read and single-generation commands.
// ----------------------------------------------------------------------------
// A command is taken on the rising edge where start is high and busy is
// low; every transaction returns exactly one result, shown on cell_value
// and out_of_range for the single cycle in which done is high. The
// receiver cannot stall, so sample the result in that cycle. After reset
// the block sweeps the board clear, one row per cycle, and holds busy
// until the last row is clear; the size registers can be written meanwhile.
// After the accepting edge, a cell write or read does one memory read, then
// the write or the bit pick, while busy is high; done follows in the next
// cycle. An out-of-range coordinate or an unused opcode is answered from
// the dispatch state without a memory access. A generation fetches, for
// each row in use, the row above, itself and the row below through the
// board memory's single read port and writes the new row to the scratch
// memory; the copy-back then writes each row back to the board memory.
// All columns of a row update in parallel lanes, so the width in use does
// not change how long a generation takes.
// Size registers: index 0 is the board width, index 1 the board height,
// both reset to 64; zero reads as 1 and values above the maximum read as
// the maximum. Write them only while the block is idle. Other indexes are
// accepted and dropped. Cells beyond the size in use keep their contents.
// ----------------------------------------------------------------------------
module life_automaton_torus import lat_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // command transaction
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [COORD_W-1:0]   row,
  input  logic [COORD_W-1:0]   col,
  input  logic                 cell_in,
  // result
  output logic                 done,
  output logic                 cell_value,
  output logic                 out_of_range,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  lat_cmd_t    cmd;
  lat_status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  lat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  lat_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .row         (row),
    .col         (col),
    .cell_in     (cell_in),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .cell_value  (cell_value),
    .out_of_range(out_of_range)
  );

endmodule

>>> sim/life_automaton_torus_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_torus_tb
// Self-checking bench for the wrapped B3/S23 life board: a shadow board in
// the bench predicts every cell write, cell read and generation, and each
// result strobe is compared against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module life_automaton_torus_tb;
  import lat_pkg::*;

  localparam int BOARD_MAX       = 64;
  localparam int RANDOM_PHASES   = 15;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int TAIL_CYCLES     = 16;   // result lands in the cycle after the last busy one
  localparam int WATCHDOG_LIMIT  = 4000; // outlasts a full-height generation
  localparam int REPORT_CAP      = 40;

  // opcode and register indexes the block accepts but does nothing with
  localparam logic [1:0]           OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_bit;
    logic               oor;
  } cell_outcome_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [1:0]           opcode    = '0;
  logic [COORD_W-1:0]   row       = '0;
  logic [COORD_W-1:0]   col       = '0;
  logic                 cell_in   = 1'b0;
  logic                 done;
  logic                 cell_value;
  logic                 out_of_range;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // shadow state: board plus the raw size registers as last written
  bit               life_cells [BOARD_MAX][BOARD_MAX];
  logic [CFG_W-1:0] width_reg  = SIZE_RESET;
  logic [CFG_W-1:0] height_reg = SIZE_RESET;

  cell_outcome_t expected_outcomes[$];
  int            mismatch_count = 0;
  int            idle_cycles    = 0;

  // stimulus side view of the size in use, and the no-gap flag
  int unsigned span_w  = BOARD_MAX;
  int unsigned span_h  = BOARD_MAX;
  bit          no_idle = 1'b0;

  life_automaton_torus #(
    .MAX_WIDTH (BOARD_MAX),
    .MAX_HEIGHT(BOARD_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .row         (row),
    .col         (col),
    .cell_in     (cell_in),
    .done        (done),
    .cell_value  (cell_value),
    .out_of_range(out_of_range),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // zero reads as one, anything past the array reads as the array size
  function automatic int unsigned size_in_use(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > BOARD_MAX) return BOARD_MAX;
    return 32'(v);
  endfunction

  // One generation over the in-use window. Each of the eight wrapped
  // neighbours is summed on its own, so on 1- or 2-wide boards a cell can
  // count itself or the same neighbour several times. Cells outside the
  // window are neither read nor touched.
  function automatic void evolve_board(int unsigned w, int unsigned h);
    bit          nxt [BOARD_MAX][BOARD_MAX];
    int unsigned r, c, up, dn, lf, rt, n;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        up = (r == 0) ? h - 1 : r - 1;
        dn = (r + 1 >= h) ? 0 : r + 1;
        lf = (c == 0) ? w - 1 : c - 1;
        rt = (c + 1 >= w) ? 0 : c + 1;
        n  = life_cells[up][lf] + life_cells[up][c] + life_cells[up][rt]
           + life_cells[r][lf]                      + life_cells[r][rt]
           + life_cells[dn][lf] + life_cells[dn][c] + life_cells[dn][rt];
        if (life_cells[r][c])
          nxt[r][c] = (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
        else
          nxt[r][c] = (n == BIRTH_COUNT);
      end
    end
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++)
        life_cells[r][c] = nxt[r][c];
  endfunction

  // apply one accepted command to the shadow board and return its result
  function automatic cell_outcome_t life_step(logic [1:0] op, logic [COORD_W-1:0] r,
                                              logic [COORD_W-1:0] c, logic v);
    cell_outcome_t res;
    int unsigned   w, h;
    w   = size_in_use(width_reg);
    h   = size_in_use(height_reg);
    res = '{op: op, row: r, col: c, cell_bit: 1'b0, oor: 1'b0};
    if (op == OP_WRITE || op == OP_READ) begin
      if (r >= h || c >= w)
        res.oor = 1'b1;
      else if (op == OP_WRITE)
        life_cells[r][c] = v;
      else
        res.cell_bit = life_cells[r][c];
    end else if (op == OP_GEN) begin
      evolve_board(w, h);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Everything is sampled on the rising edge, before this edge's updates
  // land. The result is checked before a new command is predicted, so a
  // result and an acceptance on the same edge pair up correctly.
  always @(posedge clk) begin : result_monitor
    cell_outcome_t want;
    bit            moved;
    if (!rst) begin
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: cell_value %b oor %b",
                                    cell_value, out_of_range));
        end else begin
          want = expected_outcomes.pop_front();
          if (cell_value !== want.cell_bit)
            report_mismatch($sformatf("op %0d row %0d col %0d: cell_value %b, want %b",
                                      want.op, want.row, want.col, cell_value,
                                      want.cell_bit));
          if (out_of_range !== want.oor)
            report_mismatch($sformatf("op %0d row %0d col %0d: out_of_range %b, want %b",
                                      want.op, want.row, want.col, out_of_range, want.oor));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        expected_outcomes.push_back(life_step(opcode, row, col, cell_in));
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_BOARD_WIDTH:  width_reg  = cfg_data;
          CFG_BOARD_HEIGHT: height_reg = cfg_data;
          default: ;  // spare indexes are dropped
        endcase
      end
      // watchdog: only cycles with no transaction of any kind count
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog expired with %0d results outstanding",
                 $realtime, expected_outcomes.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Start is left high after acceptance so back-to-back commands need only
  // one assignment per edge; it is dropped at the head of a gap instead.
  task automatic send_cmd(input logic [1:0] op, input logic [COORD_W-1:0] r,
                          input logic [COORD_W-1:0] c, input logic v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    opcode  <= op;
    row     <= r;
    col     <= c;
    cell_in <= v;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every outstanding result is back; queue read at the
  // falling edge, away from the monitor
  task automatic wait_drain();
    start <= 1'b0;
    do @(negedge clk); while (expected_outcomes.size() != 0);
    @(posedge clk);
  endtask

  // valid stays up between back-to-back writes, same as start
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // only called with nothing outstanding
  task automatic set_board_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input bit with_spare);
    write_reg(CFG_BOARD_WIDTH, w);
    if (with_spare)
      write_reg(CFG_SPARE_A, CFG_W'($urandom_range(0, 127)));
    write_reg(CFG_BOARD_HEIGHT, h);
    if (with_spare)
      write_reg(CFG_SPARE_B, CFG_W'($urandom_range(0, 127)));
    cfg_valid <= 1'b0;
    span_w = size_in_use(w);
    span_h = size_in_use(h);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset sizes, cleared board. Three corner cells neighbour (63,0) only
  // through wraparound, across both axes between them, so a birth there proves the wrap.
  task automatic test_corner_wrap();
    send_cmd(OP_READ,  6'd63, 6'd63, 1'b1);
    send_cmd(OP_WRITE, 6'd0,  6'd0,  1'b1);
    send_cmd(OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_cmd(OP_WRITE, 6'd0,  6'd63, 1'b1);
    send_cmd(OP_READ,  6'd0,  6'd0,  1'b0);
    send_cmd(OP_READ,  6'd63, 6'd0,  1'b0);
    send_cmd(OP_UNUSED, 6'd63, 6'd63, 1'b1);
    send_cmd(OP_GEN,   6'd63, 6'd63, 1'b1);  // fields ignored
    send_cmd(OP_READ,  6'd63, 6'd0,  1'b0);
  endtask

  // 1x2 and 2x1 boards: neighbours coincide and are each counted; also
  // coordinates beyond the size on both axes
  task automatic test_tiny_boards();
    wait_drain();
    set_board_size(7'd0, 7'd2, 1'b0);        // zero width reads as one
    send_cmd(OP_WRITE, 6'd1, 6'd0, 1'b1);
    send_cmd(OP_WRITE, 6'd0, 6'd1, 1'b1);    // past width: dropped, flagged
    send_cmd(OP_READ,  6'd2, 6'd0, 1'b0);    // past height
    send_cmd(OP_GEN,   6'd0, 6'd0, 1'b0);
    send_cmd(OP_READ,  6'd0, 6'd0, 1'b0);
    send_cmd(OP_READ,  6'd1, 6'd0, 1'b0);
    wait_drain();
    set_board_size(7'd2, 7'd1, 1'b0);
    send_cmd(OP_WRITE, 6'd0, 6'd1, 1'b1);
    send_cmd(OP_GEN,   6'd0, 6'd0, 1'b0);
    send_cmd(OP_READ,  6'd0, 6'd0, 1'b0);
    send_cmd(OP_READ,  6'd0, 6'd1, 1'b0);
  endtask

  // oversize registers clamp to the array; spare indexes leave sizes alone;
  // cells outside the earlier tiny window must have kept their values
  task automatic test_size_clamp();
    wait_drain();
    set_board_size(7'd127, 7'd127, 1'b1);
    send_cmd(OP_READ, 6'd63, 6'd0,  1'b0);
    send_cmd(OP_READ, 6'd0,  6'd63, 1'b0);
    send_cmd(OP_READ, 6'd63, 6'd63, 1'b0);
  endtask

  // Phases of random size: mostly boards up to 12 a side, every fifth one at least 40 high.
  // Most traffic is in-range writes, reads and generations; the rest is
  // unconstrained coordinates and the unused opcode.
  task automatic test_random_phases();
    int unsigned      phase, k, pick;
    logic [CFG_W-1:0] w, h;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drain();
      if (phase % 5 == 4) begin
        w = CFG_W'($urandom_range(0, 127));
        h = CFG_W'($urandom_range(40, 127));
      end else begin
        w = CFG_W'($urandom_range(0, 12));
        h = CFG_W'($urandom_range(0, 12));
      end
      set_board_size(w, h, phase % 3 == 0);
      no_idle = (phase % 4 == 2);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          send_cmd(OP_WRITE, COORD_W'($urandom_range(0, span_h - 1)),
                   COORD_W'($urandom_range(0, span_w - 1)), 1'($urandom_range(0, 1)));
        else if (pick < 70)
          send_cmd(OP_READ, COORD_W'($urandom_range(0, span_h - 1)),
                   COORD_W'($urandom_range(0, span_w - 1)), 1'($urandom_range(0, 1)));
        else if (pick < 82)
          send_cmd(OP_GEN, COORD_W'($urandom), COORD_W'($urandom),
                   1'($urandom_range(0, 1)));
        else if (pick < 95)
          send_cmd((pick % 2 == 0) ? OP_WRITE : OP_READ, COORD_W'($urandom),
                   COORD_W'($urandom), 1'($urandom_range(0, 1)));
        else
          send_cmd(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                   1'($urandom_range(0, 1)));
        // now and then let the pipe empty completely mid-phase
        if ($urandom_range(0, 49) == 0)
          wait_drain();
      end
      no_idle = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_corner_wrap();
    test_tiny_boards();
    test_size_clamp();
    test_random_phases();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
